// ===== design/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants, payload types, controller states and the command/status
// bundles that link the sort controller with its datapath.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int MAX_ITEMS = 8;
    localparam int VAL_W     = 16;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last_in;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] sorted_value;
        logic             last_out;
        logic             overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_START,
        ST_PASS_FIRST,
        ST_PASS_CMP,
        ST_PASS_END,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        WR_INPUT,
        WR_MIN,
        WR_CARRY
    } wr_sel_t;

    typedef enum logic [1:0] {
        CARRY_HOLD,
        CARRY_LOAD,
        CARRY_MAX
    } carry_op_t;

    typedef struct packed {
        logic             store_in;
        logic             wr_en;
        wr_sel_t          wr_sel;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
        carry_op_t        carry_op;
        logic             load_out;
        logic             out_last;
        logic             clear_set;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             swap;
        logic             out_free;
    } sts_t;

endpackage

// ===== design/bubble_sort_engine_unit.sv =====
// ----------------------------------------------------------------------------
// bubble_sort_engine_unit
// Collects a set of unsigned 16-bit items, sorts them in ascending order with
// an early-exit bubble sort and returns them with a last marker.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while the block is loading; at most MAX_ITEMS
// are kept and any further item of the set is dropped, which sets overflow on
// every result of that set. The item marked last starts the sort, and no input
// is taken until the final result has been loaded into the output register.
// A single comparator with a carry register walks the store through one RAM
// read port, and the sort stops after the first pass without a swap or after
// n - 1 passes over n live entries. Results are then read out one at a time,
// each waiting for the registered RAM read and for a free output register.
module bubble_sort_engine_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bse_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bse_pkg::out_item_t  m_data
);

    bse_pkg::cmd_t cmd;
    bse_pkg::sts_t sts;

    bse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_in),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bse_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .sts     (sts)
    );

`ifndef SYNTHESIS
    // A result is only loaded when the output register is empty or draining.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register overwritten while holding an item");

    // The item that closes a set makes the block busy on the next cycle.
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_in) |=> !s_ready)
        else $error("input still ready after the last item of a set");

    // A non-last item taken with room left grows the fill count by one.
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_data.last_in && !sts.full)
        |=> (sts.count == $past(sts.count) + bse_pkg::CNT_W'(1)))
        else $error("fill count did not advance on a stored item");
`endif

endmodule

// ===== design/bse_ram.sv =====
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bse_dpath.sv =====
// ----------------------------------------------------------------------------
// bse_dpath
// Element store, fill count, drop flag, compare-and-carry register for the
// bubble passes, and the output register.
// ----------------------------------------------------------------------------
module bse_dpath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bse_pkg::cmd_t        cmd,
    input  bse_pkg::in_item_t    s_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output bse_pkg::out_item_t   m_data,
    output bse_pkg::sts_t        sts
);

    logic [bse_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic                      drop_reg, drop_next;
    logic [bse_pkg::VAL_W-1:0] carry_reg, carry_next;
    logic                      out_valid_reg, out_valid_next;
    bse_pkg::out_item_t        out_reg, out_next;

    logic                      full;
    logic                      swap;
    logic [bse_pkg::VAL_W-1:0] rdata;
    logic [bse_pkg::VAL_W-1:0] min_val;
    logic [bse_pkg::VAL_W-1:0] max_val;
    logic                      ram_we;
    logic [bse_pkg::IDX_W-1:0] ram_waddr;
    logic [bse_pkg::VAL_W-1:0] ram_wdata;

    assign full    = (fill_reg == bse_pkg::CNT_W'(bse_pkg::MAX_ITEMS));
    // Strict compare keeps equal values in arrival order.
    assign swap    = (carry_reg > rdata);
    assign min_val = swap ? rdata : carry_reg;
    assign max_val = swap ? carry_reg : rdata;

    always_comb begin
        ram_we    = cmd.wr_en;
        ram_waddr = cmd.waddr;
        ram_wdata = carry_reg;
        case (cmd.wr_sel)
            bse_pkg::WR_INPUT: begin
                ram_we    = cmd.wr_en && !full;
                ram_waddr = fill_reg[bse_pkg::IDX_W-1:0];
                ram_wdata = s_data.value;
            end
            bse_pkg::WR_MIN: begin
                ram_wdata = min_val;
            end
            bse_pkg::WR_CARRY: begin
                ram_wdata = carry_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bse_ram #(
        .WIDTH (bse_pkg::VAL_W),
        .DEPTH (bse_pkg::MAX_ITEMS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmd.raddr),
        .rdata (rdata)
    );

    always_comb begin
        fill_next = fill_reg;
        drop_next = drop_reg;
        if (cmd.clear_set) begin
            fill_next = '0;
            drop_next = 1'b0;
        end else if (cmd.store_in) begin
            if (full) begin
                drop_next = 1'b1;
            end else begin
                fill_next = fill_reg + bse_pkg::CNT_W'(1);
            end
        end
    end

    always_comb begin
        case (cmd.carry_op)
            bse_pkg::CARRY_LOAD: carry_next = rdata;
            bse_pkg::CARRY_MAX:  carry_next = max_val;
            default:             carry_next = carry_reg;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (cmd.load_out) begin
            out_valid_next        = 1'b1;
            out_next.sorted_value = rdata;
            out_next.last_out     = cmd.out_last;
            out_next.overflow     = drop_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
        carry_reg <= carry_next;
        out_reg   <= out_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_data       = out_reg;
    assign sts.count    = fill_reg;
    assign sts.full     = full;
    assign sts.swap     = swap;
    assign sts.out_free = !out_valid_reg || m_ready;

endmodule

// ===== design/bse_ctrl.sv =====
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer for loading, bubble passes with early exit, and result readout.
// ----------------------------------------------------------------------------
module bse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  bse_pkg::sts_t     sts,
    output bse_pkg::cmd_t     cmd
);

    bse_pkg::state_t           state_reg, state_next;
    logic [bse_pkg::IDX_W-1:0] k_reg, k_next;
    logic [bse_pkg::IDX_W-1:0] top_reg, top_next;
    logic [bse_pkg::IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [bse_pkg::IDX_W-1:0] e_reg, e_next;
    logic                      rd_ok_reg, rd_ok_next;
    logic                      moved_reg, moved_next;

    logic                      accept;
    logic [bse_pkg::IDX_W-1:0] n_last;
    logic                      load_out;
    logic                      emit_last;
    logic                      sort_done;

    assign s_ready   = (state_reg == bse_pkg::ST_LOAD);
    assign accept    = s_valid && s_ready;
    // Index of the final stored element once the current item has been taken.
    assign n_last    = sts.full ? bse_pkg::IDX_W'(bse_pkg::MAX_ITEMS - 1)
                                : sts.count[bse_pkg::IDX_W-1:0];
    assign load_out  = (state_reg == bse_pkg::ST_EMIT) && rd_ok_reg && sts.out_free;
    assign emit_last = (e_reg == last_idx_reg);
    assign sort_done = !moved_reg || (top_reg == bse_pkg::IDX_W'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bse_pkg::ST_LOAD: begin
                if (accept && s_last) begin
                    if (n_last == '0) begin
                        state_next = bse_pkg::ST_EMIT;
                    end else begin
                        state_next = bse_pkg::ST_PASS_START;
                    end
                end
            end
            bse_pkg::ST_PASS_START: state_next = bse_pkg::ST_PASS_FIRST;
            bse_pkg::ST_PASS_FIRST: state_next = bse_pkg::ST_PASS_CMP;
            bse_pkg::ST_PASS_CMP: begin
                if (k_reg == top_reg) begin
                    state_next = bse_pkg::ST_PASS_END;
                end
            end
            bse_pkg::ST_PASS_END: begin
                if (sort_done) begin
                    state_next = bse_pkg::ST_EMIT;
                end else begin
                    state_next = bse_pkg::ST_PASS_START;
                end
            end
            bse_pkg::ST_EMIT: begin
                if (load_out && emit_last) begin
                    state_next = bse_pkg::ST_LOAD;
                end
            end
            default: state_next = bse_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.wr_sel   = bse_pkg::WR_INPUT;
        cmd.carry_op = bse_pkg::CARRY_HOLD;
        case (state_reg)
            bse_pkg::ST_LOAD: begin
                cmd.store_in = accept;
                cmd.wr_en    = accept;
            end
            bse_pkg::ST_PASS_START: begin
                cmd.raddr = '0;
            end
            bse_pkg::ST_PASS_FIRST: begin
                cmd.raddr    = bse_pkg::IDX_W'(1);
                cmd.carry_op = bse_pkg::CARRY_LOAD;
            end
            bse_pkg::ST_PASS_CMP: begin
                // The smaller of the pair settles one slot down; the larger rides on.
                cmd.raddr    = k_reg + bse_pkg::IDX_W'(1);
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = bse_pkg::WR_MIN;
                cmd.waddr    = k_reg - bse_pkg::IDX_W'(1);
                cmd.carry_op = bse_pkg::CARRY_MAX;
            end
            bse_pkg::ST_PASS_END: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bse_pkg::WR_CARRY;
                cmd.waddr  = top_reg;
            end
            bse_pkg::ST_EMIT: begin
                cmd.raddr     = e_reg;
                cmd.load_out  = load_out;
                cmd.out_last  = emit_last;
                cmd.clear_set = load_out && emit_last;
            end
            default: begin
                cmd.store_in = 1'b0;
            end
        endcase
    end

    always_comb begin
        k_next        = k_reg;
        top_next      = top_reg;
        last_idx_next = last_idx_reg;
        e_next        = e_reg;
        rd_ok_next    = rd_ok_reg;
        moved_next    = moved_reg;
        case (state_reg)
            bse_pkg::ST_LOAD: begin
                if (accept && s_last) begin
                    last_idx_next = n_last;
                    top_next      = n_last;
                    e_next        = '0;
                    rd_ok_next    = 1'b0;
                end
            end
            bse_pkg::ST_PASS_FIRST: begin
                k_next     = bse_pkg::IDX_W'(1);
                moved_next = 1'b0;
            end
            bse_pkg::ST_PASS_CMP: begin
                moved_next = moved_reg || sts.swap;
                if (k_reg != top_reg) begin
                    k_next = k_reg + bse_pkg::IDX_W'(1);
                end
            end
            bse_pkg::ST_PASS_END: begin
                if (sort_done) begin
                    e_next     = '0;
                    rd_ok_next = 1'b0;
                end else begin
                    top_next = top_reg - bse_pkg::IDX_W'(1);
                end
            end
            bse_pkg::ST_EMIT: begin
                // Read data is valid in the cycle after the address changes.
                if (load_out) begin
                    e_next     = e_reg + bse_pkg::IDX_W'(1);
                    rd_ok_next = 1'b0;
                end else begin
                    rd_ok_next = 1'b1;
                end
            end
            default: begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bse_pkg::ST_LOAD;
            rd_ok_reg <= 1'b0;
            moved_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_ok_reg <= rd_ok_next;
            moved_reg <= moved_next;
        end
        k_reg        <= k_next;
        top_reg      <= top_next;
        last_idx_reg <= last_idx_next;
        e_reg        <= e_next;
    end

endmodule

// ===== tb/bubble_sort_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bubble_sort_engine_unit_tb
// Feeds sets of 16-bit values into the sort engine and checks the sorted items
// that come back against a stable bubble sort kept in the bench. Covers single
// and full sets, repeated values, dropped items past capacity, random sets
// with random idling on both channels, and a long stall on the result side.
// ----------------------------------------------------------------------------
module bubble_sort_engine_unit_tb;

    localparam int IDLE_MAX     = 18;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 130;
    localparam int MAX_REPORTS  = 10;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    bse_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    bse_pkg::out_item_t m_data;

    // Values of the set being collected and the expected sorted items.
    logic [bse_pkg::VAL_W-1:0] open_set[$];
    bit                        open_set_dropped = 1'b0;
    bse_pkg::out_item_t        sorted_q[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit stall_req  = 1'b0;
    bit stall_ack  = 1'b0;
    int stall_left = 0;

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned items_taken   = 0;
    int unsigned sets_closed   = 0;
    int unsigned sets_dropped  = 0;
    int unsigned items_checked = 0;

    bubble_sort_engine_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d items still expected.",
                     cycle_count, sorted_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Collects one accepted value; a last item sorts the set and queues its items.
    task automatic collect_value(input logic [bse_pkg::VAL_W-1:0] v, input logic is_last);
        bse_pkg::out_item_t        r;
        logic [bse_pkg::VAL_W-1:0] hold;
        bit                        swapped;
        int                        n;
        if (open_set.size() < bse_pkg::MAX_ITEMS) begin
            open_set.push_back(v);
            items_taken++;
        end else begin
            open_set_dropped = 1'b1;
        end
        if (is_last) begin
            n = open_set.size();
            for (int p = 0; p + 1 < n; p++) begin
                swapped = 1'b0;
                for (int k = 0; k + 1 < n - p; k++) begin
                    if (open_set[k] > open_set[k+1]) begin
                        hold          = open_set[k];
                        open_set[k]   = open_set[k+1];
                        open_set[k+1] = hold;
                        swapped       = 1'b1;
                    end
                end
                if (!swapped)
                    break;
            end
            for (int k = 0; k < n; k++) begin
                r.sorted_value = open_set[k];
                r.last_out     = (k == n - 1);
                r.overflow     = open_set_dropped;
                sorted_q.push_back(r);
            end
            sets_closed++;
            if (open_set_dropped)
                sets_dropped++;
            open_set.delete();
            open_set_dropped = 1'b0;
        end
    endtask

    // Offers one item, after a random gap while input idling is on, and returns at the edge that takes it.
    task automatic push_value(input logic [bse_pkg::VAL_W-1:0] v, input logic is_last);
        bse_pkg::in_item_t item;
        int unsigned       gap;
        gap = tx_idle_on ? $urandom_range(IDLE_MAX, 0) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.value   = v;
        item.last_in = is_last;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        collect_value(v, is_last);
    endtask

    // While output idling is on, the receiver pauses a random number of cycles after each item it takes.
    initial begin : result_sink
        int unsigned pause;
        pause = $urandom_range(IDLE_MAX, 0);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready && rx_idle_on)
                pause = $urandom_range(IDLE_MAX, 0);
            if (pause != 0) begin
                pause--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (stall_left == 0);
            end
        end
    end

    initial begin : stall_timer
        forever begin
            @(posedge aclk);
            if (stall_req != stall_ack) begin
                stall_ack  <= stall_req;
                stall_left <= HOLD_CYCLES;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
            end
        end
    end

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("Mismatch on %s at cycle %0d: expected %0h, got %0h",
                     field, cycle_count, want, got);
    endtask

    always @(posedge aclk) begin : result_check
        bse_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sorted_q.size() == 0) begin
                note_mismatch("unexpected item", 0, 32'(m_data.sorted_value));
            end else begin
                want = sorted_q.pop_front();
                items_checked++;
                if (m_data.sorted_value !== want.sorted_value)
                    note_mismatch("sorted_value", 32'(want.sorted_value),
                                  32'(m_data.sorted_value));
                if (m_data.last_out !== want.last_out)
                    note_mismatch("last_out", 32'(want.last_out), 32'(m_data.last_out));
                if (m_data.overflow !== want.overflow)
                    note_mismatch("overflow", 32'(want.overflow), 32'(m_data.overflow));
            end
        end
    end

    task automatic test_single_items();
        push_value(16'hFFFF, 1'b1);
        push_value(16'h0000, 1'b1);
    endtask

    task automatic test_reversed_full_set();
        logic [bse_pkg::VAL_W-1:0] vals[bse_pkg::MAX_ITEMS];
        vals = '{16'hFFFF, 16'hFF00, 16'h8000, 16'h7FFF,
                 16'h0F0F, 16'h00FF, 16'h0001, 16'h0000};
        for (int k = 0; k < bse_pkg::MAX_ITEMS; k++)
            push_value(vals[k], k == bse_pkg::MAX_ITEMS - 1);
    endtask

    task automatic test_equal_values();
        push_value(16'h0005, 1'b0);
        push_value(16'h0005, 1'b0);
        push_value(16'h0003, 1'b0);
        push_value(16'h0005, 1'b1);
    endtask

    // Two items past capacity, the last of them closing the set.
    task automatic test_store_overflow();
        for (int k = 0; k < bse_pkg::MAX_ITEMS + 2; k++)
            push_value(bse_pkg::VAL_W'($urandom_range(16'hFFFF, 0)),
                       k == bse_pkg::MAX_ITEMS + 1);
    endtask

    task automatic test_random_sets();
        int unsigned               start_items;
        int unsigned               set_size;
        int unsigned               shape;
        logic [bse_pkg::VAL_W-1:0] base;
        logic [bse_pkg::VAL_W-1:0] step;
        logic [bse_pkg::VAL_W-1:0] pool;
        logic [bse_pkg::VAL_W-1:0] v;
        start_items = items_taken;
        while (items_taken - start_items < RANDOM_ITEMS) begin
            set_size = ($urandom_range(7, 0) == 0)
                     ? $urandom_range(bse_pkg::MAX_ITEMS + 4, bse_pkg::MAX_ITEMS + 1)
                     : $urandom_range(bse_pkg::MAX_ITEMS, 1);
            shape      = $urandom_range(3, 0);
            base       = bse_pkg::VAL_W'($urandom_range(16'h7FFF, 0));
            step       = bse_pkg::VAL_W'($urandom_range(16'h07FF, 0));
            pool       = bse_pkg::VAL_W'($urandom_range(16'hFFFF, 0));
            tx_idle_on = ($urandom_range(3, 0) != 0);
            rx_idle_on = ($urandom_range(3, 0) != 0);
            for (int k = 0; k < set_size; k++) begin
                case (shape)
                    0: v = bse_pkg::VAL_W'($urandom_range(16'hFFFF, 0));
                    1: v = bse_pkg::VAL_W'(base + k * step);
                    2: v = 16'hFFFF - bse_pkg::VAL_W'(base + k * step);
                    default: begin
                        case ($urandom_range(2, 0))
                            0: v = 16'h0000;
                            1: v = 16'hFFFF;
                            default: v = pool;
                        endcase
                    end
                endcase
                push_value(v, k == set_size - 1);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver stops for a long while so the engine fills and blocks its input.
    task automatic test_output_stall();
        stall_req  <= ~stall_req;
        tx_idle_on  = 1'b0;
        for (int s = 0; s < 3; s++)
            for (int k = 0; k < bse_pkg::MAX_ITEMS; k++)
                push_value(bse_pkg::VAL_W'($urandom_range(16'hFFFF, 0)),
                           k == bse_pkg::MAX_ITEMS - 1);
        tx_idle_on = 1'b1;
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_items();
        test_reversed_full_set();
        test_equal_values();
        test_store_overflow();
        test_random_sets();
        test_output_stall();

        s_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d stored items in %0d sets (%0d with dropped items), %0d checked.",
                 items_taken, sets_closed, sets_dropped, items_checked);
        $display("Included single-item sets, repeated values and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
